@@ hw/rtl/wfm_pkg.sv @@
// Shared types, constants and helper functions for the wall follower maze walker.
// Used by every module under hw/rtl; depends on nothing else.
package wfm_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int STEP_BITS = 16;

  localparam int POS_BITS = 5;
  localparam int HEAD_BITS = 2;
  localparam int OUT_STEP_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 5;

  localparam int MAP_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int ADDR_BITS = $clog2(MAP_DEPTH);

  // Positions are five bits wide, so the reachable grid is capped at 32.
  localparam int ROW_LIM = (GRID_ROWS < 32) ? GRID_ROWS : 32;
  localparam int COL_LIM = (GRID_COLS < 32) ? GRID_COLS : 32;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_START_X       = 3'd0,
    CFG_START_Y       = 3'd1,
    CFG_START_HEADING = 3'd2,
    CFG_EXIT_X        = 3'd3,
    CFG_EXIT_Y        = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_RESTART,
    S_PROBE,
    S_TEST,
    S_FINISH,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [POS_BITS-1:0] cell_row;
    logic [POS_BITS-1:0] cell_col;
    logic                cell_wall;
  } in_t;

  typedef struct packed {
    logic [POS_BITS-1:0]      pos_x;
    logic [POS_BITS-1:0]      pos_y;
    logic [HEAD_BITS-1:0]     heading;
    logic [OUT_STEP_BITS-1:0] step_count;
    logic                     moved;
    logic                     at_exit;
  } out_t;

  // One probed neighbour: its coordinates, whether it lies on the grid, and
  // its map address.
  typedef struct packed {
    logic [POS_BITS-1:0]  x;
    logic [POS_BITS-1:0]  y;
    logic                 in_range;
    logic [ADDR_BITS-1:0] addr;
  } nbr_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [POS_BITS-1:0] row,
                                                     input logic [POS_BITS-1:0] col);
    return ADDR_BITS'(int'(row) * GRID_COLS + int'(col));
  endfunction

  // Probe order as turns from the heading: right, ahead, left, behind.
  function automatic logic [HEAD_BITS-1:0] turn_dir(input logic [HEAD_BITS-1:0] head,
                                                    input logic [1:0]           try_k);
    logic [HEAD_BITS-1:0] dir;
    unique case (try_k)
      2'd0: dir = head + 2'd1;
      2'd1: dir = head;
      2'd2: dir = head + 2'd3;
      2'd3: dir = head + 2'd2;
      default: dir = head;
    endcase
    return dir;
  endfunction

endpackage

@@ hw/rtl/wfm_map_mem.sv @@
// Single-port wall map memory, one bit per grid cell, with registered read data.
// Depends on wfm_pkg for the depth and address width.
module wfm_map_mem
  import wfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic                 wdata,
  output logic                 rdata
);

  logic mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/wfm_nbr_unit.sv @@
// Shared neighbour unit: steps one cell from the current position in a given
// direction, checks the grid bounds and forms the map address. Depends on wfm_pkg.
module wfm_nbr_unit
  import wfm_pkg::*;
(
  input  logic [POS_BITS-1:0]  cur_x,
  input  logic [POS_BITS-1:0]  cur_y,
  input  logic [HEAD_BITS-1:0] dir,
  output nbr_t                 nbr
);

  localparam logic [POS_BITS+1:0] PLUS_ONE  = (POS_BITS+2)'(1);
  localparam logic [POS_BITS+1:0] MINUS_ONE = '1;
  localparam logic [POS_BITS+1:0] ZERO      = '0;
  localparam logic [POS_BITS+1:0] ROW_END   = (POS_BITS+2)'(ROW_LIM);
  localparam logic [POS_BITS+1:0] COL_END   = (POS_BITS+2)'(COL_LIM);

  logic [POS_BITS+1:0] dx;
  logic [POS_BITS+1:0] dy;
  logic [POS_BITS+1:0] nx;
  logic [POS_BITS+1:0] ny;

  always_comb begin
    unique case (dir)
      2'd0: begin dx = ZERO;      dy = MINUS_ONE; end
      2'd1: begin dx = PLUS_ONE;  dy = ZERO;      end
      2'd2: begin dx = ZERO;      dy = PLUS_ONE;  end
      2'd3: begin dx = MINUS_ONE; dy = ZERO;      end
      default: begin dx = ZERO;   dy = ZERO;      end
    endcase
  end

  // Two guard bits: the top one flags a step below zero.
  assign nx = {2'b00, cur_x} + dx;
  assign ny = {2'b00, cur_y} + dy;

  assign nbr.x        = nx[POS_BITS-1:0];
  assign nbr.y        = ny[POS_BITS-1:0];
  assign nbr.in_range = !nx[POS_BITS+1] && !ny[POS_BITS+1] && (nx < COL_END) && (ny < ROW_END);
  assign nbr.addr     = cell_addr(ny[POS_BITS-1:0], nx[POS_BITS-1:0]);

endmodule

@@ hw/rtl/wall_follower_maze_walker.sv @@
// Top level of the right-hand wall follower: sequencer, walker state, config
// registers and output register. Depends on wfm_pkg, wfm_map_mem and wfm_nbr_unit.
//
//   channel  signals                          direction
//   in       in_valid, in_ready, in_data      item in (in_t)
//   out      out_valid, out_ready, out_data   result out (out_t)
//   cfg      cfg_we, cfg_index, cfg_data      register write, no wait
//
// Each accepted item runs through the sequencer to S_FINISH: a map write or restart
// by way of S_WRITE or S_RESTART, an ignored item or a step after the walk is
// finished directly. A step tries up to four probes in turn: a probe on the grid
// puts its address on the single map port in S_PROBE and reads the registered data
// in S_TEST, and an off-grid neighbour skips S_TEST. After reset a clearing pass sets
// all MAP_DEPTH (1024) cells to road; no item is accepted meanwhile. A result waiting
// on out_ready holds the sequencer in S_HOLD and blocks the next item.
module wall_follower_maze_walker
  import wfm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_t                       in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_t                      out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  state_t state;
  state_t state_next;

  logic [POS_BITS-1:0]  start_x;
  logic [POS_BITS-1:0]  start_y;
  logic [HEAD_BITS-1:0] start_heading;
  logic [POS_BITS-1:0]  exit_x;
  logic [POS_BITS-1:0]  exit_y;

  logic [POS_BITS-1:0]  cur_x;
  logic [POS_BITS-1:0]  cur_y;
  logic [HEAD_BITS-1:0] cur_heading;
  logic [STEP_BITS-1:0] steps;
  logic                 finished;
  logic                 moved;
  logic [1:0]           try_k;
  logic [ADDR_BITS-1:0] clr_addr;
  in_t                  item;

  logic                 accept;
  logic                 clr_last;
  logic                 write_ok;
  logic                 out_free;
  logic [HEAD_BITS-1:0] try_dir;
  nbr_t                 nbr;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic                 mem_wdata;
  logic                 mem_rdata;

  logic                 commit;
  logic                 take;
  logic                 try_inc;
  logic                 load_out;

  logic [POS_BITS-1:0]  new_x;
  logic [POS_BITS-1:0]  new_y;
  logic [31:0]          steps_wide;

  assign accept   = in_valid && in_ready;
  assign clr_last = (clr_addr == ADDR_BITS'(MAP_DEPTH - 1));
  assign write_ok = (int'(item.cell_row) < GRID_ROWS) && (int'(item.cell_col) < GRID_COLS);
  assign out_free = !out_valid || out_ready;
  assign try_dir  = turn_dir(cur_heading, try_k);

  wfm_nbr_unit u_nbr (
    .cur_x (cur_x),
    .cur_y (cur_y),
    .dir   (try_dir),
    .nbr   (nbr)
  );

  wfm_map_mem u_map (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_data.action)
            ACT_WRITE:   state_next = S_WRITE;
            ACT_STEP:    state_next = finished ? S_FINISH : S_PROBE;
            ACT_RESTART: state_next = S_RESTART;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_WRITE, S_RESTART: state_next = S_FINISH;
      S_PROBE: begin
        if (nbr.in_range) state_next = S_TEST;
        else if (try_k == 2'd3) state_next = S_FINISH;
      end
      S_TEST: begin
        if (!mem_rdata || try_k == 2'd3) state_next = S_FINISH;
        else state_next = S_PROBE;
      end
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
        else state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = nbr.addr;
    mem_wdata = 1'b0;
    commit    = 1'b0;
    take      = 1'b0;
    try_inc   = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_addr;
      end
      S_IDLE: in_ready = 1'b1;
      S_WRITE: begin
        mem_we    = write_ok;
        mem_addr  = cell_addr(item.cell_row, item.cell_col);
        mem_wdata = item.cell_wall;
      end
      S_RESTART: ;
      S_PROBE: begin
        // An off-grid neighbour is a wall without reading the map.
        if (!nbr.in_range) begin
          if (try_k == 2'd3) commit = 1'b1;
          else try_inc = 1'b1;
        end
      end
      S_TEST: begin
        if (!mem_rdata) begin
          commit = 1'b1;
          take   = 1'b1;
        end else if (try_k == 2'd3) begin
          commit = 1'b1;
        end else begin
          try_inc = 1'b1;
        end
      end
      S_FINISH, S_HOLD: load_out = out_free;
      default: ;
    endcase
  end

  assign new_x = take ? nbr.x : cur_x;
  assign new_y = take ? nbr.y : cur_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= '0;
      exit_x        <= '0;
      exit_y        <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      cur_heading   <= '0;
      steps         <= '0;
      finished      <= 1'b0;
      moved         <= 1'b0;
      try_k         <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (state == S_CLEAR) clr_addr <= clr_addr + ADDR_BITS'(1);

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_X:       start_x       <= cfg_data;
          CFG_START_Y:       start_y       <= cfg_data;
          CFG_START_HEADING: start_heading <= cfg_data[HEAD_BITS-1:0];
          CFG_EXIT_X:        exit_x        <= cfg_data;
          CFG_EXIT_Y:        exit_y        <= cfg_data;
          default: ;
        endcase
      end

      if (accept) begin
        item  <= in_data;
        moved <= 1'b0;
        try_k <= '0;
      end else if (try_inc) begin
        try_k <= try_k + 2'd1;
      end

      if (state == S_RESTART) begin
        cur_x       <= start_x;
        cur_y       <= start_y;
        cur_heading <= start_heading;
        steps       <= '0;
        finished    <= 1'b0;
      end else if (commit) begin
        cur_x <= new_x;
        cur_y <= new_y;
        if (take) begin
          cur_heading <= try_dir;
          moved       <= 1'b1;
        end
        if (steps != '1) steps <= steps + STEP_BITS'(1);
        if (new_x == exit_x && new_y == exit_y) finished <= 1'b1;
      end

      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign steps_wide = 32'(steps);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.pos_x      <= cur_x;
      out_data.pos_y      <= cur_y;
      out_data.heading    <= cur_heading;
      out_data.step_count <= (steps_wide > 32'h0000_FFFF) ? '1 : steps_wide[OUT_STEP_BITS-1:0];
      out_data.moved      <= moved;
      out_data.at_exit    <= finished;
    end
  end

`ifndef SYNTHESIS
  // The fourth probe is the last one: the sequencer never returns to probing.
  a_probe_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_TEST && try_k == 2'd3) |=> (state == S_FINISH))
    else $error("step went on probing after the last direction");

  // Once finished, only a restart clears the walk.
  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    (finished && state != S_RESTART) |=> finished)
    else $error("finished flag dropped without a restart");

  // A transaction that reports a move must carry a nonzero step count.
  a_moved_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.moved) |-> (out_data.step_count != '0))
    else $error("move reported with a zero step count");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the right-hand wall follower maze walker.
// Depends on wfm_pkg and wall_follower_maze_walker; a queue-fed driver and a
// checking monitor run against a walker predictor kept inside this file.
module tb_top;
  import wfm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned MAX_REPORTS = 40;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NONE = 3'd7;
  localparam logic WALL = 1'b1;
  localparam logic ROAD = 1'b0;

  localparam logic [HEAD_BITS-1:0] HEAD_UP = 2'd0;
  localparam logic [HEAD_BITS-1:0] HEAD_RIGHT = 2'd1;
  localparam logic [HEAD_BITS-1:0] HEAD_DOWN = 2'd2;
  localparam logic [HEAD_BITS-1:0] HEAD_LEFT = 2'd3;

  localparam logic [POS_BITS-1:0] POS_TOP = 5'd31;

  // Probe order as turns from the heading, lowest slot first: right, ahead,
  // left, behind.
  localparam logic [7:0] PROBE_TURNS = {2'd2, 2'd3, 2'd0, 2'd1};
  localparam longint unsigned STEP_LIMIT = (64'd1 << STEP_BITS) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  wall_follower_maze_walker u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Walker predictor state.
  bit map_wall [GRID_ROWS][GRID_COLS];
  logic [POS_BITS-1:0] walker_x = '0;
  logic [POS_BITS-1:0] walker_y = '0;
  logic [HEAD_BITS-1:0] walker_head = '0;
  longint unsigned walk_steps = 0;
  bit walk_done = 1'b0;
  logic [POS_BITS-1:0] reg_start_x = '0;
  logic [POS_BITS-1:0] reg_start_y = '0;
  logic [HEAD_BITS-1:0] reg_start_head = '0;
  logic [POS_BITS-1:0] reg_exit_x = '0;
  logic [POS_BITS-1:0] reg_exit_y = '0;

  in_t walk_items [$];
  out_t due_reports [$];
  int unsigned items_queued = 0;
  int unsigned reports_matched = 0;
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit cell_open(input int row, input int col);
    if (row < 0 || col < 0 || row >= ROW_LIM || col >= COL_LIM) return 1'b0;
    return !map_wall[row][col];
  endfunction

  function automatic out_t advance_walker(input in_t item);
    out_t rep;
    logic [HEAD_BITS-1:0] dir;
    int nrow;
    int ncol;
    int k;
    bit moved;
    moved = 1'b0;
    if (item.action == ACT_WRITE) begin
      if (int'(item.cell_row) < GRID_ROWS && int'(item.cell_col) < GRID_COLS)
        map_wall[item.cell_row][item.cell_col] = item.cell_wall;
    end else if (item.action == ACT_STEP) begin
      if (!walk_done) begin
        for (k = 0; k < 4 && !moved; k++) begin
          dir = walker_head + PROBE_TURNS[2*k +: 2];
          nrow = int'(walker_y);
          ncol = int'(walker_x);
          case (dir)
            HEAD_UP: nrow = nrow - 1;
            HEAD_RIGHT: ncol = ncol + 1;
            HEAD_DOWN: nrow = nrow + 1;
            HEAD_LEFT: ncol = ncol - 1;
            default: ;
          endcase
          if (cell_open(nrow, ncol)) begin
            walker_x = POS_BITS'(ncol);
            walker_y = POS_BITS'(nrow);
            walker_head = dir;
            moved = 1'b1;
          end
        end
        if (walk_steps < STEP_LIMIT) walk_steps = walk_steps + 1;
        if (walker_x == reg_exit_x && walker_y == reg_exit_y) walk_done = 1'b1;
      end
    end else if (item.action == ACT_RESTART) begin
      walker_x = reg_start_x;
      walker_y = reg_start_y;
      walker_head = reg_start_head;
      walk_steps = 0;
      walk_done = 1'b0;
    end
    rep.pos_x = walker_x;
    rep.pos_y = walker_y;
    rep.heading = walker_head;
    rep.step_count = (walk_steps > 64'd65535) ? 16'hFFFF : 16'(walk_steps);
    rep.moved = moved;
    rep.at_exit = walk_done;
    return rep;
  endfunction

  // Driver: offers queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) due_reports.push_back(advance_walker(in_data));
      if (!in_valid || in_ready) begin
        if (walk_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= walk_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Monitor: checks each result transaction and drives out_ready, with a long
  // hold-off whenever one has been requested.
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = due_reports.pop_front();
          reports_matched++;
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("heading", want.heading, out_data.heading);
          check_field("step_count", want.step_count, out_data.step_count);
          check_field("moved", want.moved, out_data.moved);
          check_field("at_exit", want.at_exit, out_data.at_exit);
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
        hold_seen <= hold_asked;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wall_follower_maze_walker: mismatch");
      $finish;
    end
  end

  function automatic in_t make_item(input logic [1:0] action, input logic [POS_BITS-1:0] row,
                                    input logic [POS_BITS-1:0] col, input logic wall);
    in_t it;
    it.action = action;
    it.cell_row = row;
    it.cell_col = col;
    it.cell_wall = wall;
    return it;
  endfunction

  task automatic offer(input in_t it);
    walk_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (reports_matched != items_queued) @(posedge clk);
  endtask

  task automatic write_config(input logic [POS_BITS-1:0] sx, input logic [POS_BITS-1:0] sy,
                              input logic [CFG_DATA_BITS-1:0] head,
                              input logic [POS_BITS-1:0] ex, input logic [POS_BITS-1:0] ey);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_X;
    cfg_data <= sx;
    @(posedge clk);
    cfg_index <= CFG_START_Y;
    cfg_data <= sy;
    @(posedge clk);
    cfg_index <= CFG_START_HEADING;
    cfg_data <= head;
    @(posedge clk);
    cfg_index <= CFG_EXIT_X;
    cfg_data <= ex;
    @(posedge clk);
    cfg_index <= CFG_EXIT_Y;
    cfg_data <= ey;
    // An index past the last register must leave everything alone.
    @(posedge clk);
    cfg_index <= CFG_NONE;
    cfg_data <= CFG_DATA_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_start_x = sx;
    reg_start_y = sy;
    reg_start_head = head[HEAD_BITS-1:0];
    reg_exit_x = ex;
    reg_exit_y = ey;
  endtask

  function automatic logic [POS_BITS-1:0] pick_coord();
    case ($urandom_range(5))
      0: return '0;
      1: return POS_TOP;
      default: return POS_BITS'($urandom);
    endcase
  endfunction

  // Mostly steps, with wall edits (most near the start) so the path keeps changing.
  function automatic in_t random_item(input logic [POS_BITS-1:0] cx,
                                      input logic [POS_BITS-1:0] cy);
    in_t it;
    int unsigned pick;
    it.cell_row = POS_BITS'($urandom);
    it.cell_col = POS_BITS'($urandom);
    it.cell_wall = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.action = ACT_WRITE;
    end else if (pick < 18) begin
      it.action = ACT_WRITE;
      it.cell_row = cy + POS_BITS'($urandom_range(6)) - POS_BITS'(3);
      it.cell_col = cx + POS_BITS'($urandom_range(6)) - POS_BITS'(3);
    end else if (pick < 22) begin
      it.action = ACT_RESTART;
    end else if (pick < 24) begin
      it.action = ACT_UNUSED;
    end else begin
      it.action = ACT_STEP;
    end
    return it;
  endfunction

  task automatic run_maze_phase(input int unsigned send_idle, input int unsigned recv_stall,
                                input int unsigned n_items, input bit long_hold);
    logic [POS_BITS-1:0] sx;
    logic [POS_BITS-1:0] sy;
    logic [POS_BITS-1:0] ex;
    logic [POS_BITS-1:0] ey;
    int unsigned i;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    sx = pick_coord();
    sy = pick_coord();
    // Keep the exit close to the start most of the time so that it is reached.
    if ($urandom_range(9) < 7) begin
      ex = sx + POS_BITS'($urandom_range(2)) - POS_BITS'(1);
      ey = sy + POS_BITS'($urandom_range(2)) - POS_BITS'(1);
    end else begin
      ex = pick_coord();
      ey = pick_coord();
    end
    write_config(sx, sy, CFG_DATA_BITS'($urandom), ex, ey);
    offer(make_item(ACT_RESTART, '0, '0, ROAD));
    for (i = 0; i < 16; i++)
      offer(make_item(ACT_WRITE, sy + POS_BITS'($urandom_range(4)) - POS_BITS'(2),
                      sx + POS_BITS'($urandom_range(4)) - POS_BITS'(2),
                      ($urandom_range(99) < 40) ? WALL : ROAD));
    for (i = 0; i < n_items / 2; i++) offer(random_item(sx, sy));
    if (long_hold) hold_asked++;
    // The sender pauses here until every outstanding result has come back.
    wait_drained();
    for (i = n_items / 2; i < n_items; i++) offer(random_item(sx, sy));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: start and exit are both the top-left cell.
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_UNUSED, POS_TOP, POS_TOP, WALL));
    offer(make_item(ACT_RESTART, POS_TOP, '0, WALL));
    offer(make_item(ACT_WRITE, 5'd0, 5'd1, WALL));
    offer(make_item(ACT_WRITE, 5'd1, 5'd0, WALL));
    offer(make_item(ACT_STEP, '0, '0, ROAD));           // boxed in on the exit
    offer(make_item(ACT_STEP, POS_TOP, POS_TOP, WALL)); // walk already finished
    offer(make_item(ACT_WRITE, POS_TOP, POS_TOP, WALL));
    offer(make_item(ACT_WRITE, POS_TOP, POS_TOP, ROAD));
    offer(make_item(ACT_RESTART, '0, '0, ROAD));
    offer(make_item(ACT_WRITE, 5'd1, 5'd0, ROAD));
    offer(make_item(ACT_STEP, '0, '0, ROAD));           // only the cell behind is open
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_WRITE, 5'd0, 5'd1, ROAD));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Bottom-right corner facing right: only the left turn and behind are on the grid.
    write_config(POS_TOP, POS_TOP, CFG_DATA_BITS'(HEAD_RIGHT), POS_TOP, 5'd30);
    offer(make_item(ACT_RESTART, '0, '0, ROAD));
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_RESTART, '0, '0, ROAD));
    offer(make_item(ACT_WRITE, 5'd30, POS_TOP, WALL));
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_WRITE, 5'd30, POS_TOP, ROAD));

    run_maze_phase(0, 0, 330, 1'b1);
    run_maze_phase(47, 0, 330, 1'b0);
    run_maze_phase(0, 47, 330, 1'b1);
    run_maze_phase(13, 13, 330, 1'b0);

    // Boxed into the corner with the exit far away: steps stay put but still
    // count, until the cell below opens up.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    idle_pct = 0;
    stall_pct = 0;
    write_config('0, '0, CFG_DATA_BITS'(HEAD_UP), POS_TOP, POS_TOP);
    offer(make_item(ACT_WRITE, 5'd0, 5'd1, WALL));
    offer(make_item(ACT_WRITE, 5'd1, 5'd0, WALL));
    offer(make_item(ACT_RESTART, '0, '0, ROAD));
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_WRITE, 5'd1, 5'd0, ROAD));
    offer(make_item(ACT_STEP, '0, '0, ROAD));
    offer(make_item(ACT_STEP, '0, '0, ROAD));

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_reports.size() != 0) begin
      mismatches++;
      $display("%0t: results outstanding, expected 0, got %0d", $time, due_reports.size());
    end
    if (mismatches == 0) begin
      $display("wall_follower_maze_walker: match");
    end else begin
      $display("wall_follower_maze_walker: mismatch");
    end
    $finish;
  end

endmodule
